// File: src/inverse_map_nearest_scatter_core_assert.svh
// ----------------------------------------------------------------------------
// Inverse map nearest scatter assertion macros
// Shared concurrent assertion forms clocked on aclk and idle during reset.
// ----------------------------------------------------------------------------
`ifndef INVERSE_MAP_NEAREST_SCATTER_CORE_ASSERT_SVH
`define INVERSE_MAP_NEAREST_SCATTER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define IMNS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define IMNS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: src/imns_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse map nearest scatter package
// Codes, command and status types and small helper functions shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
package imns_pkg;

    localparam int DIST_W = 19;
    localparam logic [DIST_W-1:0] DIST_ONE = 19'd131072;
    localparam int OUT_COORD_W = 12;
    localparam int CNT_W = 4;
    localparam logic [CNT_W-1:0] NB_COUNT = 4'd9;
    localparam logic [CNT_W-1:0] NB_LAST = 4'd8;

    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 10;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_WIDTH = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAP_HEIGHT = 2'd1;
    localparam logic [CFG_DATA_W-1:0] CFG_SIZE_RESET = 10'd512;

    typedef enum logic [1:0] {
        ACT_SCATTER = 2'd0,
        ACT_READ    = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_NOP     = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_SCAT = 2'd1,
        KIND_READ = 2'd2
    } out_kind_t;

    typedef struct packed {
        logic             load;
        logic             clr_start;
        logic             clr_wr;
        logic             scat_rd;
        logic [CNT_W-1:0] nb;
        logic             rd_entry;
        logic             out_load;
        out_kind_t        out_kind;
    } cmd_t;

    typedef struct packed {
        logic margin_ok;
        logic clr_last;
    } status_t;

    // Rounds a signed Q10.8 value to the nearest integer, ties to even.
    function automatic logic [11:0] round_q8(input logic [18:0] v);
        logic [18:0] u;
        logic        up;
        u  = {~v[18], v[17:0]};
        up = (u[7:0] > 8'd128) || ((u[7:0] == 8'd128) && u[8]);
        return {1'b0, u[18:8]} + {11'd0, up} - 12'd1024;
    endfunction

    function automatic logic [1:0] nb_col_off(input logic [CNT_W-1:0] k);
        logic [1:0] r;
        case (k) inside
            4'd0, 4'd3, 4'd6: r = 2'd0;
            4'd1, 4'd4, 4'd7: r = 2'd1;
            4'd2, 4'd5, 4'd8: r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] nb_row_off(input logic [CNT_W-1:0] k);
        logic [1:0] r;
        case (k) inside
            [4'd0:4'd2]: r = 2'd0;
            [4'd3:4'd5]: r = 2'd1;
            [4'd6:4'd8]: r = 2'd2;
            default: r = 2'd0;
        endcase
        return r;
    endfunction

endpackage

// File: src/imns_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse map nearest scatter datapath
// Holds the size registers, the item registers, the inverse map store with
// its compare and update stage, the clear address counter and the result
// register.
// ----------------------------------------------------------------------------
`include "inverse_map_nearest_scatter_core_assert.svh"

module imns_datapath #(
    parameter int MAP_WIDTH_MAX  = 512,
    parameter int MAP_HEIGHT_MAX = 512,
    parameter int COORD_BITS     = 12
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [imns_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [imns_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  imns_pkg::cmd_t                      cmd,
    output imns_pkg::status_t                   status,
    input  logic [11:0]                         src_col,
    input  logic [11:0]                         src_row,
    input  logic signed [18:0]                  map_x,
    input  logic signed [18:0]                  map_y,
    input  logic [8:0]                          read_x,
    input  logic [8:0]                          read_y,
    output logic [imns_pkg::OUT_COORD_W-1:0]    out_col,
    output logic [imns_pkg::OUT_COORD_W-1:0]    out_row,
    output logic [imns_pkg::DIST_W-1:0]         out_dist,
    output logic [imns_pkg::CNT_W-1:0]          updated_count
);
    import imns_pkg::*;

    localparam int DEPTH = MAP_WIDTH_MAX * MAP_HEIGHT_MAX;
    localparam int AW = $clog2(DEPTH);
    localparam int CW = 2 * COORD_BITS;
    localparam int WORD_W = CW + DIST_W;
    localparam logic [AW-1:0] ADDR_LAST = AW'(DEPTH - 1);
    localparam logic [AW-1:0] ROW_STRIDE = AW'(MAP_WIDTH_MAX);
    localparam logic [13:0] W_LIM = 14'(MAP_WIDTH_MAX);
    localparam logic [13:0] H_LIM = 14'(MAP_HEIGHT_MAX);
    localparam logic [DIST_W-1:0] DIST_MAX = 19'd294912;

    logic [CFG_DATA_W-1:0] map_width_reg;
    logic [CFG_DATA_W-1:0] map_height_reg;

    logic signed [18:0] px_reg;
    logic signed [18:0] py_reg;
    logic [CW-1:0]      coords_reg;
    logic [8:0]         rdx_reg;
    logic [8:0]         rdy_reg;
    logic [11:0]        rx_reg;
    logic [11:0]        ry_reg;
    logic               rd_in_range_reg;

    logic               p_valid_reg;
    logic [AW-1:0]      p_addr_reg;
    logic [DIST_W-1:0]  p_dist_reg;
    logic [AW-1:0]      clr_addr_reg;
    logic [CNT_W-1:0]   cnt_reg;

    logic [WORD_W-1:0]  mem [DEPTH];
    logic [WORD_W-1:0]  rd_word_reg;

    logic [13:0]        w_eff;
    logic [13:0]        h_eff;
    logic signed [13:0] rx_ext;
    logic signed [13:0] ry_ext;
    logic [11:0]        nx;
    logic [11:0]        ny;
    logic signed [9:0]  dx;
    logic signed [9:0]  dy;
    logic [19:0]        sq_x;
    logic [19:0]        sq_y;
    logic [DIST_W-1:0]  dist_nb;
    logic [AW-1:0]      addr_nb;
    logic [AW-1:0]      addr_rd;
    logic [AW-1:0]      rd_addr;
    logic               rd_en;
    logic [DIST_W-1:0]  rd_dist;
    logic [CW-1:0]      rd_coords;
    logic               take;
    logic               we;
    logic [AW-1:0]      wr_addr;
    logic [WORD_W-1:0]  wr_data;

    always_comb begin
        w_eff = ({4'd0, map_width_reg} < W_LIM) ? {4'd0, map_width_reg} : W_LIM;
        h_eff = ({4'd0, map_height_reg} < H_LIM) ? {4'd0, map_height_reg} : H_LIM;
        rx_ext = {{2{rx_reg[11]}}, rx_reg};
        ry_ext = {{2{ry_reg[11]}}, ry_reg};
        status.margin_ok = (rx_ext > 14'sd1) && (ry_ext > 14'sd1)
                           && ((rx_ext + 14'sd1) < $signed(w_eff))
                           && ((ry_ext + 14'sd1) < $signed(h_eff));
        status.clr_last = (clr_addr_reg == ADDR_LAST);
    end

    always_comb begin
        nx = rx_reg + {10'd0, nb_col_off(cmd.nb)} - 12'd1;
        ny = ry_reg + {10'd0, nb_row_off(cmd.nb)} - 12'd1;
        dx = px_reg[9:0] - {nx[1:0], 8'd0};
        dy = py_reg[9:0] - {ny[1:0], 8'd0};
        sq_x = dx * dx;
        sq_y = dy * dy;
        dist_nb = DIST_W'(sq_x + sq_y);
        addr_nb = AW'(ny) * ROW_STRIDE + AW'(nx);
        addr_rd = AW'(rdy_reg) * ROW_STRIDE + AW'(rdx_reg);
        rd_addr = cmd.scat_rd ? addr_nb : addr_rd;
        rd_en = cmd.scat_rd || cmd.rd_entry;
        rd_dist = rd_word_reg[DIST_W-1:0];
        rd_coords = rd_word_reg[WORD_W-1:DIST_W];
        take = p_valid_reg && (p_dist_reg < rd_dist);
        we = cmd.clr_wr || take;
        wr_addr = cmd.clr_wr ? clr_addr_reg : p_addr_reg;
        wr_data = cmd.clr_wr ? {{CW{1'b0}}, DIST_ONE} : {coords_reg, p_dist_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            map_width_reg <= CFG_SIZE_RESET;
            map_height_reg <= CFG_SIZE_RESET;
            p_valid_reg <= 1'b0;
            clr_addr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (cfg_wr_en && (cfg_index == CFG_MAP_WIDTH)) begin
                map_width_reg <= cfg_wdata;
            end
            if (cfg_wr_en && (cfg_index == CFG_MAP_HEIGHT)) begin
                map_height_reg <= cfg_wdata;
            end
            p_valid_reg <= cmd.scat_rd;
            if (cmd.clr_start) begin
                clr_addr_reg <= '0;
            end else if (cmd.clr_wr) begin
                clr_addr_reg <= clr_addr_reg + AW'(1);
            end
            if (cmd.load) begin
                cnt_reg <= '0;
            end else if (take) begin
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            px_reg <= map_x;
            py_reg <= map_y;
            coords_reg <= {COORD_BITS'(src_row), COORD_BITS'(src_col)};
            rdx_reg <= read_x;
            rdy_reg <= read_y;
            rx_reg <= round_q8(map_x);
            ry_reg <= round_q8(map_y);
        end
        if (cmd.rd_entry) begin
            rd_in_range_reg <= ({23'd0, rdx_reg} < 32'(MAP_WIDTH_MAX))
                               && ({23'd0, rdy_reg} < 32'(MAP_HEIGHT_MAX));
        end
        if (cmd.scat_rd) begin
            p_addr_reg <= addr_nb;
            p_dist_reg <= dist_nb;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_word_reg <= mem[rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            case (cmd.out_kind)
                KIND_READ: begin
                    if (rd_in_range_reg) begin
                        out_col <= OUT_COORD_W'(rd_coords[COORD_BITS-1:0]);
                        out_row <= OUT_COORD_W'(rd_coords[CW-1:COORD_BITS]);
                        out_dist <= rd_dist;
                    end else begin
                        out_col <= '0;
                        out_row <= '0;
                        out_dist <= DIST_ONE;
                    end
                    updated_count <= '0;
                end
                KIND_SCAT: begin
                    out_col <= '0;
                    out_row <= '0;
                    out_dist <= '0;
                    updated_count <= cnt_reg;
                end
                default: begin
                    out_col <= '0;
                    out_row <= '0;
                    out_dist <= '0;
                    updated_count <= '0;
                end
            endcase
        end
    end

    `IMNS_ASSERT_NOW(a_no_write_clash, p_valid_reg, !cmd.clr_wr, "Update collides with clear.")
    `IMNS_ASSERT_NOW(a_cnt_max, cmd.out_load, cnt_reg <= NB_COUNT, "Update count above nine.")
    `IMNS_ASSERT_NOW(a_dist_max, p_valid_reg, p_dist_reg <= DIST_MAX, "Distance out of range.")

endmodule

// File: src/imns_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse map nearest scatter controller
// Sequences the clearing pass, the neighbor walk of a scatter, entry reads
// and the hand-off of each result to the output register.
// ----------------------------------------------------------------------------
`include "inverse_map_nearest_scatter_core_assert.svh"

module imns_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  imns_pkg::action_t   s_action,
    output logic                m_tvalid,
    input  logic                m_tready,
    output imns_pkg::cmd_t      cmd,
    input  imns_pkg::status_t   status
);
    import imns_pkg::*;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_CHECK,
        ST_SCAT,
        ST_DRAIN,
        ST_RD_ISSUE,
        ST_RESULT
    } state_t;

    state_t           state_reg, state_next;
    logic [CNT_W-1:0] nb_reg, nb_next;
    out_kind_t        kind_reg, kind_next;
    logic             clr_report_reg, clr_report_next;
    logic             m_tvalid_reg, m_tvalid_next;
    logic             accept;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign accept = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        nb_next = nb_reg;
        kind_next = kind_reg;
        clr_report_next = clr_report_reg;
        cmd = '0;
        cmd.nb = nb_reg;
        cmd.out_kind = kind_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (status.clr_last) begin
                    clr_report_next = 1'b0;
                    kind_next = KIND_NONE;
                    state_next = clr_report_reg ? ST_RESULT : ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    cmd.load = 1'b1;
                    case (s_action)
                        ACT_SCATTER: state_next = ST_CHECK;
                        ACT_READ: state_next = ST_RD_ISSUE;
                        ACT_CLEAR: begin
                            cmd.clr_start = 1'b1;
                            clr_report_next = 1'b1;
                            state_next = ST_CLEAR;
                        end
                        default: begin
                            kind_next = KIND_NONE;
                            state_next = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_CHECK: begin
                if (status.margin_ok) begin
                    nb_next = '0;
                    state_next = ST_SCAT;
                end else begin
                    kind_next = KIND_NONE;
                    state_next = ST_RESULT;
                end
            end
            ST_SCAT: begin
                cmd.scat_rd = 1'b1;
                nb_next = nb_reg + CNT_W'(1);
                if (nb_reg == NB_LAST) begin
                    state_next = ST_DRAIN;
                end
            end
            ST_DRAIN: begin
                kind_next = KIND_SCAT;
                state_next = ST_RESULT;
            end
            ST_RD_ISSUE: begin
                cmd.rd_entry = 1'b1;
                kind_next = KIND_READ;
                state_next = ST_RESULT;
            end
            ST_RESULT: begin
                if (!m_tvalid_reg || m_tready) begin
                    cmd.out_load = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
        if (cmd.out_load) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
            nb_reg <= '0;
            kind_reg <= KIND_NONE;
            clr_report_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            nb_reg <= nb_next;
            kind_reg <= kind_next;
            clr_report_reg <= clr_report_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    `IMNS_ASSERT_NEXT(a_one_item, s_tvalid && s_tready, !s_tready, "Second item taken early.")
    `IMNS_ASSERT_NOW(a_slot_free, cmd.out_load, !m_tvalid_reg || m_tready, "Result overwritten.")
    `IMNS_ASSERT_NOW(a_nb_range, state_reg == ST_SCAT, nb_reg < NB_COUNT, "Neighbor index overrun.")

endmodule

// File: src/inverse_map_nearest_scatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse map nearest scatter core
// Builds an inverse warp map by scattering forward-map samples to the 3x3
// neighbors of their rounded target, keeping the nearest source per entry.
// ----------------------------------------------------------------------------
// The block handles one transaction at a time and returns exactly one result
// transaction for each. A scatter holds the input through acceptance, the
// margin test, a walk over the nine neighbors (one entry per cycle through a
// store with one read and one write port, the compare and update trailing
// each read into the next cycle), a drain of that update stage and the result
// load. A failed margin test goes on to the result, a read issues its entry
// read first and an unused action goes straight to the result. A clear sweeps
// the store's MAP_WIDTH_MAX * MAP_HEIGHT_MAX entries (262144 at the defaults)
// one entry per cycle. After reset the same sweep runs with no result, and no
// input transaction is taken until it ends; size writes are taken throughout.
// A pending result does not stop the next transaction from being accepted.
// ----------------------------------------------------------------------------

module inverse_map_nearest_scatter_core #(
    parameter int MAP_WIDTH_MAX  = 512,
    parameter int MAP_HEIGHT_MAX = 512,
    parameter int COORD_BITS     = 12
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // src_col, src_row, map_x, map_y, read_x, read_y
    input  logic [79:0]                     s_tdata,
    // action
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // out_col, out_row, out_dist, updated_count, zero pad
    output logic [47:0]                     m_tdata,
    input  logic                            cfg_wr_en,
    input  logic [imns_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imns_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import imns_pkg::*;

    cmd_t                   cmd;
    status_t                status;
    logic [11:0]            s_src_col;
    logic [11:0]            s_src_row;
    logic signed [18:0]     s_map_x;
    logic signed [18:0]     s_map_y;
    logic [8:0]             s_read_x;
    logic [8:0]             s_read_y;
    logic [OUT_COORD_W-1:0] m_out_col;
    logic [OUT_COORD_W-1:0] m_out_row;
    logic [DIST_W-1:0]      m_out_dist;
    logic [CNT_W-1:0]       m_updated_count;

    assign s_src_col = s_tdata[11:0];
    assign s_src_row = s_tdata[23:12];
    assign s_map_x = s_tdata[42:24];
    assign s_map_y = s_tdata[61:43];
    assign s_read_x = s_tdata[70:62];
    assign s_read_y = s_tdata[79:71];
    assign m_tdata = {1'b0, m_updated_count, m_out_dist, m_out_row, m_out_col};

    imns_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_action (action_t'(s_tuser)),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    imns_datapath #(
        .MAP_WIDTH_MAX  (MAP_WIDTH_MAX),
        .MAP_HEIGHT_MAX (MAP_HEIGHT_MAX),
        .COORD_BITS     (COORD_BITS)
    ) u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .cmd           (cmd),
        .status        (status),
        .src_col       (s_src_col),
        .src_row       (s_src_row),
        .map_x         (s_map_x),
        .map_y         (s_map_y),
        .read_x        (s_read_x),
        .read_y        (s_read_y),
        .out_col       (m_out_col),
        .out_row       (m_out_row),
        .out_dist      (m_out_dist),
        .updated_count (m_updated_count)
    );

endmodule

// File: tb/sv/tb_inverse_map_nearest_scatter_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Inverse map nearest scatter core testbench
// Drives scatter, read, clear and idle transactions into the core over several
// map size settings. Each result is checked field by field against its table
// entry or a sparse software copy of the inverse map. A short table of directed
// cases runs first, followed by random traffic aimed at small hot regions so
// that neighbors compete for entries. Random stalls on both sides, one long
// receiver hold-off and a cycle watchdog are part of the run.
// ----------------------------------------------------------------------------

module tb_inverse_map_nearest_scatter_core;
    import imns_pkg::*;

    localparam int MAP_SIDE       = 512;
    localparam int ITEMS_PER_PHASE = 292;
    localparam int PHASES         = 6;
    localparam int DRAIN_CYCLES   = 40;
    localparam int STALL_LIMIT    = 800000;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        action_t     act;
        logic [11:0] src_col;
        logic [11:0] src_row;
        logic [18:0] map_x;
        logic [18:0] map_y;
        logic [8:0]  read_x;
        logic [8:0]  read_y;
    } map_cmd_t;

    typedef struct packed {
        logic [11:0] col;
        logic [11:0] row;
        logic [18:0] dist_q16;
        logic [3:0]  count;
    } map_entry_t;

    typedef struct packed {
        map_cmd_t   cmd;
        logic       typed;
        map_entry_t want;
    } directed_row_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [79:0]           s_tdata;
    logic [1:0]            s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [47:0]           m_tdata;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    logic [18:0]   dist_store [int];
    logic [23:0]   coord_store [int];
    int            size_w;
    int            size_h;
    map_entry_t    expected_entries [$];
    directed_row_t directed_rows [$];

    int err_count;
    int stall_cycles;
    int rx_hold_cycles;
    bit stalls_on;
    int n_scatter;
    int n_scatter_hit;
    int n_read;
    int n_clear;
    int n_nop;
    int n_results;
    int n_settings;

    inverse_map_nearest_scatter_core i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Rounds a signed Q10.8 position to the nearest pixel, ties to even.
    function automatic int nearest_pixel(input int v);
        int fl;
        int fr;
        fl = v >>> 8;
        fr = v & 255;
        if (fr > 128 || (fr == 128 && fl[0])) begin
            fl = fl + 1;
        end
        return fl;
    endfunction

    function automatic map_entry_t apply_to_map(input map_cmd_t c);
        map_entry_t  r;
        int          weff;
        int          heff;
        int          px;
        int          py;
        int          cx;
        int          cy;
        int          nx;
        int          ny;
        int          dx;
        int          dy;
        int          d;
        int          idx;
        logic [18:0] best;
        r = '0;
        case (c.act)
            ACT_SCATTER: begin
                weff = (size_w < MAP_SIDE) ? size_w : MAP_SIDE;
                heff = (size_h < MAP_SIDE) ? size_h : MAP_SIDE;
                px = {{13{c.map_x[18]}}, c.map_x};
                py = {{13{c.map_y[18]}}, c.map_y};
                cx = nearest_pixel(px);
                cy = nearest_pixel(py);
                if (cx > 1 && cy > 1 && cx < weff - 1 && cy < heff - 1) begin
                    for (int k = 0; k < 9; k++) begin
                        nx = cx - 1 + k % 3;
                        ny = cy - 1 + k / 3;
                        dx = px - nx * 256;
                        dy = py - ny * 256;
                        d = dx * dx + dy * dy;
                        idx = ny * MAP_SIDE + nx;
                        best = dist_store.exists(idx) ? dist_store[idx] : DIST_ONE;
                        if (d < int'(best)) begin
                            dist_store[idx] = 19'(d);
                            coord_store[idx] = {c.src_row, c.src_col};
                            r.count = r.count + 4'd1;
                        end
                    end
                end
            end
            ACT_READ: begin
                idx = int'(c.read_y) * MAP_SIDE + int'(c.read_x);
                r.dist_q16 = dist_store.exists(idx) ? dist_store[idx] : DIST_ONE;
                if (coord_store.exists(idx)) begin
                    {r.row, r.col} = coord_store[idx];
                end
            end
            ACT_CLEAR: begin
                dist_store.delete();
                coord_store.delete();
            end
            default: begin
            end
        endcase
        return r;
    endfunction

    function automatic void add_row(input action_t a, input int col, input int row,
                                    input int mx, input int my, input int rdx, input int rdy,
                                    input logic typed, input int wc, input int wr,
                                    input int wd, input int wn);
        directed_row_t t;
        t.cmd.act       = a;
        t.cmd.src_col   = 12'(col);
        t.cmd.src_row   = 12'(row);
        t.cmd.map_x     = 19'(mx);
        t.cmd.map_y     = 19'(my);
        t.cmd.read_x    = 9'(rdx);
        t.cmd.read_y    = 9'(rdy);
        t.typed         = typed;
        t.want.col      = 12'(wc);
        t.want.row      = 12'(wr);
        t.want.dist_q16 = 19'(wd);
        t.want.count    = 4'(wn);
        directed_rows.push_back(t);
    endfunction

    function automatic int pick_target(input int hot, input int hi);
        int t;
        t = hot + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 9) != 0) begin
            if (t < 2) begin
                t = 2;
            end
            if (t > hi) begin
                t = hi;
            end
        end
        return t;
    endfunction

    function automatic map_cmd_t make_random_item(input int hot_x, input int hot_y,
                                                  input int x_hi, input int y_hi);
        map_cmd_t c;
        int       r;
        c.src_col = 12'($urandom);
        c.src_row = 12'($urandom);
        c.map_x   = 19'($urandom);
        c.map_y   = 19'($urandom);
        c.read_x  = 9'($urandom);
        c.read_y  = 9'($urandom);
        r = $urandom_range(0, 99);
        if (r < 55) begin
            c.act = ACT_SCATTER;
            if ($urandom_range(0, 6) != 0) begin
                c.map_x = 19'(pick_target(hot_x, x_hi) * 256
                              + int'($urandom_range(0, 255)) - 128);
                c.map_y = 19'(pick_target(hot_y, y_hi) * 256
                              + int'($urandom_range(0, 255)) - 128);
            end
        end else if (r < 93) begin
            c.act = ACT_READ;
            if ($urandom_range(0, 3) != 0) begin
                c.read_x = 9'(hot_x + int'($urandom_range(0, 6)) - 3);
                c.read_y = 9'(hot_y + int'($urandom_range(0, 6)) - 3);
            end
        end else begin
            c.act = ACT_NOP;
        end
        return c;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input int value);
        cfg_wr_en <= 1'b1;
        cfg_index <= index;
        cfg_wdata <= CFG_DATA_W'(value);
        if (index == CFG_MAP_WIDTH) begin
            size_w = value & 32'h3FF;
        end else if (index == CFG_MAP_HEIGHT) begin
            size_h = value & 32'h3FF;
        end
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic set_size(input int w, input int h);
        write_reg(CFG_MAP_WIDTH, w);
        write_reg(CFG_MAP_HEIGHT, h);
        n_settings++;
    endtask

    task automatic push_item(input map_cmd_t c, input logic typed, input map_entry_t want);
        map_entry_t pred;
        s_tvalid <= 1'b1;
        s_tuser  <= c.act;
        s_tdata  <= {c.read_y, c.read_x, c.map_y, c.map_x, c.src_row, c.src_col};
        @(posedge aclk);
        while (!s_tready) begin
            @(posedge aclk);
        end
        pred = apply_to_map(c);
        expected_entries.push_back(typed ? want : pred);
        case (c.act)
            ACT_SCATTER: begin
                n_scatter++;
                if (pred.count != 0) begin
                    n_scatter_hit++;
                end
            end
            ACT_READ:  n_read++;
            ACT_CLEAR: n_clear++;
            default:   n_nop++;
        endcase
        @(negedge aclk);
    endtask

    task automatic idle_tx(input int cycles);
        s_tvalid <= 1'b0;
        repeat (cycles) @(negedge aclk);
    endtask

    task automatic maybe_idle_tx();
        if (stalls_on && $urandom_range(0, 5) == 0) begin
            idle_tx($urandom_range(1, 4));
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (expected_entries.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    initial begin
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (rx_hold_cycles > 0) begin
                m_tready <= 1'b0;
                repeat (rx_hold_cycles - 1) @(negedge aclk);
                rx_hold_cycles = 0;
            end else if (stalls_on && $urandom_range(0, 7) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 4) - 1) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge aclk) begin : result_check
        map_entry_t got;
        map_entry_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got.col      = m_tdata[11:0];
            got.row      = m_tdata[23:12];
            got.dist_q16 = m_tdata[42:24];
            got.count    = m_tdata[46:43];
            n_results++;
            if (expected_entries.size() == 0) begin
                $display("%0t: result transaction expected none, got %h",
                         $time, got);
                err_count++;
            end else begin
                want = expected_entries.pop_front();
                if (got.col !== want.col) begin
                    $display("%0t: out_col expected %0d, got %0d", $time, want.col, got.col);
                    err_count++;
                end
                if (got.row !== want.row) begin
                    $display("%0t: out_row expected %0d, got %0d", $time, want.row, got.row);
                    err_count++;
                end
                if (got.dist_q16 !== want.dist_q16) begin
                    $display("%0t: out_dist expected %0d, got %0d",
                             $time, want.dist_q16, got.dist_q16);
                    err_count++;
                end
                if (got.count !== want.count) begin
                    $display("%0t: updated_count expected %0d, got %0d",
                             $time, want.count, got.count);
                    err_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stall_cycles = 0;
        end else begin
            stall_cycles = stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: watchdog expired after %0d cycles without a transaction",
                         $time, stall_cycles);
                $display("Some tests failed");
                $finish;
            end
        end
    end

    initial begin : stimulus
        map_cmd_t   c;
        map_entry_t none;
        int         weff;
        int         heff;
        int         x_hi;
        int         y_hi;
        int         hot_x;
        int         hot_y;

        aresetn        = 1'b0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        s_tuser        = ACT_NOP;
        cfg_wr_en      = 1'b0;
        cfg_index      = CFG_MAP_WIDTH;
        cfg_wdata      = '0;
        size_w         = CFG_SIZE_RESET;
        size_h         = CFG_SIZE_RESET;
        err_count      = 0;
        stall_cycles   = 0;
        rx_hold_cycles = 0;
        stalls_on      = 1'b1;
        none           = '0;

        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        add_row(ACT_READ,    0,    0,       0,      0,   0,   0, 1'b1,    0, 0, DIST_ONE, 0);
        add_row(ACT_READ,    0,    0,       0,      0, 511, 511, 1'b1,    0, 0, DIST_ONE, 0);
        add_row(ACT_NOP,  4095, 4095,      -1,     -1, 511, 511, 1'b1,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 4095, 0,    2560,   2560,   0,   0, 1'b1,    0, 0,        0, 5);
        add_row(ACT_READ,    0,    0,       0,      0,  10,  10, 1'b1, 4095, 0,        0, 0);
        add_row(ACT_READ,    0,    0,       0,      0,  11,  10, 1'b1, 4095, 0,    65536, 0);
        add_row(ACT_READ,    0,    0,       0,      0,  11,  11, 1'b1,    0, 0, DIST_ONE, 0);
        add_row(ACT_SCATTER, 1,    2,    2688,   3200,   0,   0, 1'b0,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 3,    4,    2944,   2944,   0,   0, 1'b0,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 5,    6,    2689,   2431,   0,   0, 1'b0,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 7,    8,     256,   2560,   0,   0, 1'b1,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 9,   10,     512,    512,   0,   0, 1'b0,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 11,  12,  130560,   2560,   0,   0, 1'b0,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 13,  14,  130816,   2560,   0,   0, 1'b1,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 15,  16, -262144,   2560,   0,   0, 1'b1,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 17,  18,    2560, 262143,   0,   0, 1'b1,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 19,  20,    2560,    383,   0,   0, 1'b1,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 21,  22,    2560, 130560,   0,   0, 1'b0,    0, 0,        0, 0);
        add_row(ACT_SCATTER, 0, 4095,    2576,   2560,   0,   0, 1'b0,    0, 0,        0, 0);
        add_row(ACT_READ,    0,    0,       0,      0,  10,  10, 1'b0,    0, 0,        0, 0);
        add_row(ACT_READ,    0,    0,       0,      0, 511,  10, 1'b0,    0, 0,        0, 0);
        add_row(ACT_CLEAR, 4095, 4095,     -1,     -1, 511, 511, 1'b1,    0, 0,        0, 0);
        add_row(ACT_READ,    0,    0,       0,      0,  10,  10, 1'b1,    0, 0, DIST_ONE, 0);
        add_row(ACT_NOP,     0,    0,       0,      0,   0,   0, 1'b1,    0, 0,        0, 0);

        set_size(512, 512);
        foreach (directed_rows[i]) begin
            push_item(directed_rows[i].cmd, directed_rows[i].typed, directed_rows[i].want);
            maybe_idle_tx();
        end
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: set_size(512, 512);
                1: set_size(4, 4);
                2: set_size(1023, 600);
                3: begin
                    c = '0;
                    c.act = ACT_CLEAR;
                    push_item(c, 1'b0, none);
                    wait_drained();
                    set_size($urandom_range(4, 512), $urandom_range(4, 512));
                end
                4: begin
                    set_size(0, 1023);
                    write_reg(CFG_SPARE_A, 10'h3FF);
                    write_reg(CFG_SPARE_B, 0);
                end
                default: begin
                    set_size($urandom_range(0, 1023), $urandom_range(0, 1023));
                    stalls_on = 1'b0;
                end
            endcase
            weff  = (size_w < MAP_SIDE) ? size_w : MAP_SIDE;
            heff  = (size_h < MAP_SIDE) ? size_h : MAP_SIDE;
            x_hi  = (weff >= 4) ? weff - 2 : 2;
            y_hi  = (heff >= 4) ? heff - 2 : 2;
            hot_x = $urandom_range(2, x_hi);
            hot_y = $urandom_range(2, y_hi);
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                if (phase == 0 && n == 120) begin
                    rx_hold_cycles = 300;
                end
                if (n % 73 == 72) begin
                    hot_x = $urandom_range(2, x_hi);
                    hot_y = $urandom_range(2, y_hi);
                end
                push_item(make_random_item(hot_x, hot_y, x_hi, y_hi), 1'b0, none);
                maybe_idle_tx();
            end
            wait_drained();
        end

        $display("Covered %0d transactions: %0d scatters (%0d writing entries), %0d reads,",
                 n_scatter + n_read + n_clear + n_nop, n_scatter, n_scatter_hit, n_read);
        $display("%0d clears and %0d idle actions over %0d map size settings; %0d results checked.",
                 n_clear, n_nop, n_settings, n_results);
        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/imns_pkg.sv
src/imns_datapath.sv
src/imns_ctrl.sv
src/inverse_map_nearest_scatter_core.sv
tb/sv/tb_inverse_map_nearest_scatter_core.sv
